/* rtl/lfk_pkg.sv */
// ----------------------------------------------------------------------------
// lfk_pkg: shared types and constants of the leg forward kinematics core
// Holds widths, the CORDIC arctangent table and the front-to-back word format.
// ----------------------------------------------------------------------------
package lfk_pkg;

	localparam int NUM_LEGS     = 4;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int LEG_W        = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
	localparam int ANG_W        = 16;
	localparam int POS_W        = 20;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 18;
	localparam int Q_W          = 34; // CORDIC x/y working width (Q30 plus growth)
	localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
	localparam int QDEPTH       = 2;

	localparam logic signed [Q_W-1:0] CORDIC_X0 = 34'sd652032874;

	localparam logic [CFG_IDX_W-1:0] REG_THIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOOT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R2P    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIP_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIP_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIP_Z  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNS  = 3'd7;

	// One accepted word as the front end hands it to the back end.
	typedef struct packed {
		logic                  fr_pos;
		logic                  sd_pos;
		logic [ANGLE_BITS-1:0] ph_r;
		logic [ANGLE_BITS-1:0] ph_p;
		logic [ANGLE_BITS-1:0] ph_pk;
	} lfk_job_t;

	// Arctangent of 2^-i in 1/2^32 turn, rounded half up to ANGLE_BITS.
	function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] i);
		logic [31:0] t;
		logic [32:0] r;
		case (i)
			5'd0: t = 32'd536870912;   5'd1: t = 32'd316933406;
			5'd2: t = 32'd167458908;   5'd3: t = 32'd85004757;
			5'd4: t = 32'd42667331;    5'd5: t = 32'd21354465;
			5'd6: t = 32'd10679838;    5'd7: t = 32'd5340245;
			5'd8: t = 32'd2670163;     5'd9: t = 32'd1335087;
			5'd10: t = 32'd667544;     5'd11: t = 32'd333772;
			5'd12: t = 32'd166886;     5'd13: t = 32'd83443;
			5'd14: t = 32'd41722;      5'd15: t = 32'd20861;
			5'd16: t = 32'd10430;      5'd17: t = 32'd5215;
			5'd18: t = 32'd2608;       5'd19: t = 32'd1304;
			5'd20: t = 32'd652;        5'd21: t = 32'd326;
			5'd22: t = 32'd163;        5'd23: t = 32'd81;
			default: t = 32'd0;
		endcase
		r = {1'b0, t} + (33'd1 << (31 - ANGLE_BITS));
		atan_step = r[32-ANGLE_BITS +: ANGLE_BITS];
	endfunction

	// Length times Q30 trig value, rounded half up to the length's units.
	// Lengths and reaches stay within 24 signed bits and trig values within 32.
	function automatic logic signed [39:0] mulq(input logic signed [39:0] a,
	                                             input logic signed [Q_W-1:0] t);
		logic signed [23:0] a_n;
		logic signed [31:0] t_n;
		logic signed [55:0] p;
		a_n = a[23:0];
		t_n = t[31:0];
		p = 56'(a_n) * 56'(t_n) + 56'sd536870912;
		mulq = 40'(p >>> 30);
	endfunction

	function automatic logic signed [POS_W-1:0] sat(input logic signed [39:0] v);
		if (v > 40'sd524287)
			sat = 20'sd524287;
		else if (v < -40'sd524288)
			sat = -20'sd524288;
		else
			sat = v[POS_W-1:0];
	endfunction

endpackage

/* rtl/lfk_front.sv */
// ----------------------------------------------------------------------------
// lfk_front: input stage
// Takes a word, clamps the leg, looks up its signs and forms the three phases.
// ----------------------------------------------------------------------------
module lfk_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [lfk_pkg::LEG_W-1:0]       leg_index,
	input  logic signed [15:0]              roll_angle,
	input  logic signed [15:0]              pitch_angle,
	input  logic signed [15:0]              knee_angle,
	input  logic [7:0]                      signs,
	output logic                            job_valid,
	output lfk_pkg::lfk_job_t               job
);

	logic [lfk_pkg::LEG_W-1:0]      leg_c;
	logic [lfk_pkg::ANGLE_BITS-1:0] pr, pp, pk;
	logic                           valid_q;
	lfk_pkg::lfk_job_t              job_q;

	function automatic logic [lfk_pkg::ANGLE_BITS-1:0] to_phase(input logic [15:0] raw);
		if (lfk_pkg::ANGLE_BITS >= 16)
			to_phase = lfk_pkg::ANGLE_BITS'({raw, 8'd0} >> (24 - lfk_pkg::ANGLE_BITS));
		else
			to_phase = lfk_pkg::ANGLE_BITS'(raw >> (16 - lfk_pkg::ANGLE_BITS));
	endfunction

	always_comb begin
		if (32'(leg_index) >= lfk_pkg::NUM_LEGS)
			leg_c = lfk_pkg::LEG_W'(lfk_pkg::NUM_LEGS - 1);
		else
			leg_c = leg_index;
		pr = to_phase(roll_angle);
		pp = to_phase(pitch_angle);
		pk = to_phase(knee_angle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q.fr_pos <= signs[{leg_c, 1'b0}];
			job_q.sd_pos <= signs[{leg_c, 1'b1}];
			job_q.ph_r   <= pr;
			job_q.ph_p   <= pp;
			job_q.ph_pk  <= pp + pk;
		end
	end

	assign job_valid = valid_q;
	assign job       = job_q;

endmodule

/* rtl/lfk_queue.sv */
// ----------------------------------------------------------------------------
// lfk_queue: short word queue between the front and back ends
// Register FIFO; the front only writes when a slot is known to be free.
// ----------------------------------------------------------------------------
module lfk_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lfk_pkg::lfk_job_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output logic [1:0]        count,
	output lfk_pkg::lfk_job_t head
);

	lfk_pkg::lfk_job_t mem_q [lfk_pkg::QDEPTH];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

	assign not_empty = cnt_q != 2'd0;
	assign count     = cnt_q;
	assign head      = mem_q[rp_q];

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != 2'd2) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

/* rtl/lfk_back.sv */
// ----------------------------------------------------------------------------
// lfk_back: CORDIC and point generation
// Three CORDIC lanes share a step counter; then products are formed in the
// M1, M2 and M3 states and the four points leave one per cycle from ST_OUT.
// ----------------------------------------------------------------------------
module lfk_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  lfk_pkg::lfk_job_t                job,
	output logic                             job_pop,
	input  logic [16:0]                      thigh_len,
	input  logic [16:0]                      calf_len,
	input  logic [15:0]                      foot_rad,
	input  logic [16:0]                      r2p_len,
	input  logic signed [17:0]               hip_x,
	input  logic signed [17:0]               hip_y,
	input  logic signed [17:0]               hip_z,
	output logic                             pt_valid,
	output logic [1:0]                       pt_index,
	output logic signed [lfk_pkg::POS_W-1:0] pt_x,
	output logic signed [lfk_pkg::POS_W-1:0] pt_y,
	output logic signed [lfk_pkg::POS_W-1:0] pt_z,
	output logic                             pt_last
);

	localparam int QW = lfk_pkg::Q_W;
	localparam int AW = lfk_pkg::ANGLE_BITS + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ROT  = 7'b0000010,
		ST_M1   = 7'b0000100,
		ST_M2   = 7'b0001000,
		ST_M3   = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_DONE = 7'b1000000
	} bk_state_t;

	bk_state_t                 state_q;
	logic [lfk_pkg::STEP_W-1:0] step_q;
	logic [1:0]                pt_q;
	logic signed [QW-1:0]      x_q [3];
	logic signed [QW-1:0]      y_q [3];
	logic signed [AW-1:0]      z_q [3];
	logic                      flip_q [3];
	logic                      fr_q, sd_q;
	logic signed [39:0]        l1c_q, l1s_q, kx_q, rk_q, fx3_q, rf3_q;
	logic signed [39:0]        rks_q, rkc_q, rfs_q, rfc_q;
	logic signed [39:0]        hx_q, hy_q, hz_q;
	logic signed [QW-1:0]      cr, sr;
	logic signed [39:0]        l1, l2, l3, rf;
	logic [lfk_pkg::ANGLE_BITS-1:0] a_step;
	logic signed [39:0]        px, py, pz;
	logic                      pt_valid_q, pt_last_q;
	logic [1:0]                pt_index_q;
	logic signed [lfk_pkg::POS_W-1:0] pt_x_q, pt_y_q, pt_z_q;

	// Quarter-turn fold: result negated when the angle is moved by a half turn.
	function automatic logic [AW:0] fold(input logic [lfk_pkg::ANGLE_BITS-1:0] ph);
		logic signed [AW-1:0] z;
		logic signed [AW-1:0] quarter;
		logic signed [AW-1:0] half;
		logic                 f;
		quarter = AW'(1) <<< (lfk_pkg::ANGLE_BITS - 2);
		half    = AW'(1) <<< (lfk_pkg::ANGLE_BITS - 1);
		z = AW'(signed'(ph));
		f = 1'b0;
		if (z > quarter) begin
			z = z - half;
			f = 1'b1;
		end else if (z < -quarter) begin
			z = z + half;
			f = 1'b1;
		end
		fold = {f, z};
	endfunction

	assign a_step = lfk_pkg::atan_step(5'(step_q));
	assign job_pop = (state_q == ST_IDLE || state_q == ST_DONE) && job_valid;

	always_comb begin
		cr = flip_q[0] ? -x_q[0] : x_q[0];
		sr = flip_q[0] ? -y_q[0] : y_q[0];
		l1 = sd_q ? 40'(r2p_len) : -40'(r2p_len);
		l2 = 40'(thigh_len);
		l3 = 40'(calf_len) + 40'(foot_rad);
		rf = rk_q + rf3_q;
		case (pt_q)
			2'd0: begin
				px = hx_q; py = hy_q; pz = hz_q;
			end
			2'd1: begin
				px = hx_q; py = hy_q + l1c_q; pz = hz_q + l1s_q;
			end
			2'd2: begin
				px = hx_q + kx_q; py = hy_q + l1c_q + rks_q; pz = hz_q + l1s_q - rkc_q;
			end
			default: begin
				px = hx_q + kx_q - fx3_q;
				py = hy_q + l1c_q + rfs_q;
				pz = hz_q + l1s_q - rfc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			pt_q       <= 2'd0;
			pt_valid_q <= 1'b0;
		end else begin
			pt_valid_q <= state_q == ST_OUT;
			case (state_q)
				ST_IDLE, ST_DONE: begin
					state_q <= job_valid ? ST_ROT : ST_IDLE;
					step_q  <= '0;
				end
				ST_ROT: begin
					step_q <= step_q + 1'b1;
					if (32'(step_q) == lfk_pkg::CORDIC_STEPS - 1)
						state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					state_q <= ST_OUT;
					pt_q    <= 2'd0;
				end
				ST_OUT: begin
					pt_q <= pt_q + 2'd1;
					if (pt_q == 2'd3)
						state_q <= ST_DONE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [AW:0] f0, f1, f2;
		f0 = fold(job.ph_r);
		f1 = fold(job.ph_p);
		f2 = fold(job.ph_pk);
		if (job_pop) begin
			fr_q <= job.fr_pos;
			sd_q <= job.sd_pos;
			x_q[0] <= lfk_pkg::CORDIC_X0; x_q[1] <= lfk_pkg::CORDIC_X0;
			x_q[2] <= lfk_pkg::CORDIC_X0;
			y_q[0] <= '0; y_q[1] <= '0; y_q[2] <= '0;
			z_q[0] <= f0[AW-1:0]; flip_q[0] <= f0[AW];
			z_q[1] <= f1[AW-1:0]; flip_q[1] <= f1[AW];
			z_q[2] <= f2[AW-1:0]; flip_q[2] <= f2[AW];
		end else if (state_q == ST_ROT) begin
			for (int k = 0; k < 3; k++) begin
				if (z_q[k] >= 0) begin
					x_q[k] <= x_q[k] - (y_q[k] >>> step_q);
					y_q[k] <= y_q[k] + (x_q[k] >>> step_q);
					z_q[k] <= z_q[k] - AW'(a_step);
				end else begin
					x_q[k] <= x_q[k] + (y_q[k] >>> step_q);
					y_q[k] <= y_q[k] - (x_q[k] >>> step_q);
					z_q[k] <= z_q[k] + AW'(a_step);
				end
			end
		end
		if (state_q == ST_M1) begin
			hx_q  <= fr_q ? 40'(hip_x) : -40'(hip_x);
			hy_q  <= sd_q ? 40'(hip_y) : -40'(hip_y);
			hz_q  <= 40'(hip_z);
			l1c_q <= lfk_pkg::mulq(l1, cr);
			l1s_q <= lfk_pkg::mulq(l1, sr);
			kx_q  <= -lfk_pkg::mulq(l2, flip_q[1] ? -y_q[1] : y_q[1]);
			rk_q  <= lfk_pkg::mulq(l2, flip_q[1] ? -x_q[1] : x_q[1]);
			fx3_q <= lfk_pkg::mulq(l3, flip_q[2] ? -y_q[2] : y_q[2]);
			rf3_q <= lfk_pkg::mulq(l3, flip_q[2] ? -x_q[2] : x_q[2]);
		end
		if (state_q == ST_M2) begin
			rks_q <= lfk_pkg::mulq(rk_q, sr);
			rkc_q <= lfk_pkg::mulq(rk_q, cr);
		end
		if (state_q == ST_M3) begin
			rfs_q <= lfk_pkg::mulq(rf, sr);
			rfc_q <= lfk_pkg::mulq(rf, cr);
		end
		if (state_q == ST_OUT) begin
			pt_index_q <= pt_q;
			pt_last_q  <= pt_q == 2'd3;
			pt_x_q     <= lfk_pkg::sat(px);
			pt_y_q     <= lfk_pkg::sat(py);
			pt_z_q     <= lfk_pkg::sat(pz);
		end
	end

	assign pt_valid = pt_valid_q;
	assign pt_index = pt_index_q;
	assign pt_last  = pt_last_q;
	assign pt_x     = pt_x_q;
	assign pt_y     = pt_y_q;
	assign pt_z     = pt_z_q;

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !(state_q == ST_ROT || state_q == ST_OUT)) else $error("pop while busy");
	a_last_foot: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_last |-> pt_index == 2'd3) else $error("last flag off foot");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_index != 2'd0 |-> $past(pt_valid)) else $error("points out of order");
`endif

endmodule

/* rtl/leg_forward_kinematics_core.sv */
// ----------------------------------------------------------------------------
// leg_forward_kinematics_core: three-joint leg forward kinematics
// Four body-frame points per joint word, CORDIC sine and cosine.
// ----------------------------------------------------------------------------
// A word (leg_index and three binary angles) is taken when start is high and
// busy low. The four points, hip mount, roll-to-pitch joint, knee and foot,
// appear on consecutive cycles, each marked by done for one cycle, the foot
// with last_point set; the receiver cannot stall them. The back end works one
// word at a time: it picks the word up, the shared CORDIC step counter
// iterates the roll, pitch and pitch-plus-knee lanes together, the M1, M2
// and M3 product states follow, then the output state. A two-word queue sits
// between the input stage and the back end, so up to two words can be taken
// while one is being worked; busy is high while the queue and the input
// stage together hold two words that are not being popped.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be written while no word is in flight.
module leg_forward_kinematics_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lfk_pkg::LEG_W-1:0]            leg_index,
	input  logic signed [15:0]                   roll_angle,
	input  logic signed [15:0]                   pitch_angle,
	input  logic signed [15:0]                   knee_angle,
	input  logic                                 cfg_we,
	input  logic [lfk_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lfk_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 done,
	output logic [1:0]                           point_index,
	output logic signed [lfk_pkg::POS_W-1:0]     pos_x,
	output logic signed [lfk_pkg::POS_W-1:0]     pos_y,
	output logic signed [lfk_pkg::POS_W-1:0]     pos_z,
	output logic                                 last_point
);

	logic [16:0]        thigh_q, calf_q, r2p_q;
	logic [15:0]        foot_q;
	logic signed [17:0] hx_q, hy_q, hz_q;
	logic [7:0]         signs_q;
	logic               take, job_valid, pop, q_ne;
	logic [1:0]         q_cnt;
	lfk_pkg::lfk_job_t  job, head;

	// Registers are reset to zero; a write to an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thigh_q <= '0; calf_q <= '0; foot_q <= '0; r2p_q <= '0;
			hx_q <= '0; hy_q <= '0; hz_q <= '0; signs_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lfk_pkg::REG_THIGH: thigh_q <= cfg_data[16:0];
				lfk_pkg::REG_CALF:  calf_q  <= cfg_data[16:0];
				lfk_pkg::REG_FOOT:  foot_q  <= cfg_data[15:0];
				lfk_pkg::REG_R2P:   r2p_q   <= cfg_data[16:0];
				lfk_pkg::REG_HIP_X: hx_q    <= cfg_data;
				lfk_pkg::REG_HIP_Y: hy_q    <= cfg_data;
				lfk_pkg::REG_HIP_Z: hz_q    <= cfg_data;
				lfk_pkg::REG_SIGNS: signs_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The input stage holds one word, the queue two; busy keeps total <= 2
	// words beyond the one leaving the queue.
	assign busy = (32'(q_cnt) + 32'(job_valid) - 32'(pop)) >= lfk_pkg::QDEPTH;
	assign take = start && !busy;

	lfk_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .leg_index(leg_index),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .knee_angle(knee_angle),
		.signs(signs_q), .job_valid(job_valid), .job(job)
	);

	lfk_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(job_valid), .push_data(job), .pop(pop),
		.not_empty(q_ne), .count(q_cnt), .head(head)
	);

	lfk_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_ne), .job(head), .job_pop(pop),
		.thigh_len(thigh_q), .calf_len(calf_q), .foot_rad(foot_q), .r2p_len(r2p_q),
		.hip_x(hx_q), .hip_y(hy_q), .hip_z(hz_q),
		.pt_valid(done), .pt_index(point_index), .pt_x(pos_x), .pt_y(pos_y),
		.pt_z(pos_z), .pt_last(last_point)
	);

`ifndef SYNTH
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take) else $error("word taken while busy");
	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_point |=> done) else $error("point burst broken");
	a_first_point: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> point_index == 2'd0) else $error("burst starts mid-way");
`endif

endmodule
